[rtl/lzw_pkg.sv]
// Shared constants and codes for the LZW dictionary encoder.
package lzw_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CODES   = 4096;
    localparam int DEF_SYMBOL_BITS = 8;

    // Fixed field widths of the stream words and the configuration register
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 12;
    localparam int NEXT_W  = 13;
    localparam int CFG_W   = 9;
    localparam int TDATA_W = 32;

    // Alphabet size after reset
    localparam logic [CFG_W-1:0] START_CODES_RESET = 9'd256;

    // Multiplicative hash constant for the home slot
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    // Item opcodes carried in s_tuser
    typedef enum logic [0:0] {
        OP_ENCODE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

endpackage

[rtl/lzw_dictionary_encoder.sv]
// LZW encoder dictionary step: hashed dictionary in one synchronous memory.
//
// Each word on the s_ side is either a symbol to encode or a dictionary clear
// (s_tuser). Every input word yields exactly one result word on the m_ side.
// An encode word is settled on the first probe when the (prefix, symbol) pair
// sits at its hash slot or the slot is empty; otherwise linear probing steps
// over each occupied slot that holds a foreign key, and the probe loop is one
// read of the dictionary memory per cycle. A word whose symbol is outside the
// alphabet, or that starts a new prefix, needs no lookup. After reset and
// after every clear word the dictionary memory is swept, one entry per cycle,
// over all MAX_CODES entries (4096 by default); meanwhile no input word is taken;
// configuration writes are taken at any time. MAX_CODES must be a power of
// two. A result waiting on the m_ side does not block the next input word
// until that word's own result is ready.
module lzw_dictionary_encoder #(
    parameter int MAX_CODES   = lzw_pkg::DEF_MAX_CODES,
    parameter int SYMBOL_BITS = lzw_pkg::DEF_SYMBOL_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: start_codes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lzw_pkg::CFG_W-1:0]    cfg_data,
    // input words
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lzw_pkg::SYM_W-1:0]    s_tdata,   // [7:0] symbol
    input  logic                         s_tuser,   // [0] opcode
    // result words
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lzw_pkg::TDATA_W-1:0]  m_tdata,   // [11:0] code, [24:12] next_code,
                                                    // [25] dict_full, [31:26] zero
    output logic                         m_tuser    // [0] code_valid
);
    import lzw_pkg::*;

    localparam int AW     = $clog2(MAX_CODES);
    localparam int FW     = AW + 1;
    localparam int KEY_W  = AW + SYM_W;
    localparam int MEM_W  = 1 + KEY_W + AW;
    localparam int WIDE_W = (FW > NEXT_W) ? FW : NEXT_W;

    localparam logic [SYM_W-1:0] SYM_MASK  = SYM_W'((1 << SYMBOL_BITS) - 1);
    localparam logic [CFG_W-1:0] ALPHA_TOP = CFG_W'(1 << SYMBOL_BITS);
    localparam logic [CFG_W-1:0] ALPHA_MIN = CFG_W'(2);
    localparam logic [CFG_W-1:0] ALPHA_RESET =
        (START_CODES_RESET > ALPHA_TOP) ? ALPHA_TOP : START_CODES_RESET;
    localparam logic [FW-1:0]    FREE_MAX  = FW'(MAX_CODES);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    // Dictionary memory: {valid, key, code} per slot
    logic [MEM_W-1:0] dict_mem [MAX_CODES];
    logic [MEM_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [MEM_W-1:0] wr_data;

    // Control and dictionary state
    state_t            state_reg,        state_next;
    logic [AW-1:0]     clr_cnt_reg,      clr_cnt_next;
    logic              emit_reg,         emit_next;
    logic [CFG_W-1:0]  start_codes_reg,  start_codes_next;
    logic [CFG_W-1:0]  alpha_reg,        alpha_next;
    logic [FW-1:0]     free_reg,         free_next;
    logic [AW-1:0]     prefix_reg,       prefix_next;
    logic              prefix_empty_reg, prefix_empty_next;
    logic [SYM_W-1:0]  sym_reg,          sym_next;
    logic [KEY_W-1:0]  key_reg,          key_next;
    logic [AW-1:0]     slot_reg,         slot_next;

    // Result waiting for the output register
    logic              pend_valid_reg,   pend_valid_next;
    logic [AW-1:0]     pend_code_reg,    pend_code_next;
    logic              pend_full_reg,    pend_full_next;

    // Output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_tuser_reg,  m_tuser_next;
    logic [TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    // Datapath helpers
    logic               out_free;
    logic [SYM_W-1:0]   sym_in;
    logic [KEY_W-1:0]   key_in;
    logic [31:0]        hash_prod;
    logic [CFG_W-1:0]   alpha_clamped;
    logic               rd_valid;
    logic [KEY_W-1:0]   rd_key;
    logic [AW-1:0]      rd_code;
    logic               ld;
    logic               ld_valid;
    logic [AW-1:0]      ld_code;
    logic [FW-1:0]      ld_free;
    logic               ld_full;
    logic [WIDE_W-1:0]  code_wide;
    logic [WIDE_W-1:0]  next_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign sym_in    = s_tdata & SYM_MASK;
    assign key_in    = {prefix_reg, sym_in};
    assign hash_prod = 32'(key_in) * HASH_MULT;

    assign rd_valid  = rd_data_reg[MEM_W-1];
    assign rd_key    = rd_data_reg[MEM_W-2 -: KEY_W];
    assign rd_code   = rd_data_reg[AW-1:0];

    // Clamp the configured alphabet into [2, 2^SYMBOL_BITS]
    always_comb
    begin
        if (start_codes_reg < ALPHA_MIN)
        begin
            alpha_clamped = ALPHA_MIN;
        end
        else if (start_codes_reg > ALPHA_TOP)
        begin
            alpha_clamped = ALPHA_TOP;
        end
        else
        begin
            alpha_clamped = start_codes_reg;
        end
    end

    // Read the home slot on accept, the following slot while probing
    always_comb
    begin
        case (state_reg)
            S_PROBE: rd_addr = slot_reg + 1'b1;
            default: rd_addr = hash_prod[AW-1:0];
        endcase
    end

    // Dictionary memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dict_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= dict_mem[rd_addr];
    end

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        emit_next         = emit_reg;
        start_codes_next  = start_codes_reg;
        alpha_next        = alpha_reg;
        free_next         = free_reg;
        prefix_next       = prefix_reg;
        prefix_empty_next = prefix_empty_reg;
        sym_next          = sym_reg;
        key_next          = key_reg;
        slot_next         = slot_reg;
        pend_valid_next   = pend_valid_reg;
        pend_code_next    = pend_code_reg;
        pend_full_next    = pend_full_reg;
        wr_en             = 1'b0;
        wr_addr           = slot_reg;
        wr_data           = {1'b1, key_reg, free_reg[AW-1:0]};
        ld                = 1'b0;
        ld_valid          = pend_valid_reg;
        ld_code           = pend_code_reg;
        ld_free           = free_reg;
        ld_full           = pend_full_reg;

        // Take configuration writes at any time
        if (cfg_valid)
        begin
            start_codes_next = cfg_data;
        end

        case (state_reg)
            // Invalidate one dictionary slot per cycle
            S_SWEEP:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {AW{1'b1}})
                begin
                    state_next = emit_reg ? S_DONE : S_IDLE;
                    emit_next  = 1'b0;
                end
            end

            // Accept a word and settle the cases that need no lookup
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pend_valid_next = 1'b0;
                    pend_code_next  = '0;
                    pend_full_next  = 1'b0;
                    case (s_tuser)
                        OP_CLEAR:
                        begin
                            alpha_next        = alpha_clamped;
                            free_next         = FW'(alpha_clamped);
                            prefix_empty_next = 1'b1;
                            clr_cnt_next      = '0;
                            emit_next         = 1'b1;
                            state_next        = S_SWEEP;
                        end
                        OP_ENCODE:
                        begin
                            if ({1'b0, sym_in} >= alpha_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else if (prefix_empty_reg)
                            begin
                                prefix_next       = AW'(sym_in);
                                prefix_empty_next = 1'b0;
                                state_next        = S_DONE;
                            end
                            else
                            begin
                                sym_next   = sym_in;
                                key_next   = key_in;
                                slot_next  = hash_prod[AW-1:0];
                                state_next = S_PROBE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Compare the slot just read; step on past a foreign key
            S_PROBE:
            begin
                if (rd_valid && (rd_key != key_reg))
                begin
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    if (rd_valid)
                    begin
                        // Known pair: advance the prefix
                        prefix_next     = rd_code;
                        pend_valid_next = 1'b0;
                        pend_code_next  = '0;
                        pend_full_next  = 1'b0;
                    end
                    else
                    begin
                        // New pair: emit the prefix, add the entry if room
                        pend_valid_next = 1'b1;
                        pend_code_next  = prefix_reg;
                        if (free_reg < FREE_MAX)
                        begin
                            wr_en          = 1'b1;
                            free_next      = free_reg + 1'b1;
                            pend_full_next = 1'b0;
                        end
                        else
                        begin
                            pend_full_next = 1'b1;
                        end
                        prefix_next = AW'(sym_reg);
                    end
                    ld_valid = pend_valid_next;
                    ld_code  = pend_code_next;
                    ld_free  = free_next;
                    ld_full  = pend_full_next;
                    if (out_free)
                    begin
                        ld         = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // Hold the result until the output register frees up
            S_DONE:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Fit the result fields to the word layout
    assign code_wide = WIDE_W'(ld_code);
    assign next_wide = WIDE_W'(ld_free);

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        if (ld)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = ld_valid;
            m_tdata_next  = {{(TDATA_W - CODE_W - NEXT_W - 1){1'b0}}, ld_full,
                             next_wide[NEXT_W-1:0], code_wide[CODE_W-1:0]};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            clr_cnt_reg      <= '0;
            emit_reg         <= 1'b0;
            start_codes_reg  <= START_CODES_RESET;
            alpha_reg        <= ALPHA_RESET;
            free_reg         <= FW'(ALPHA_RESET);
            prefix_empty_reg <= 1'b1;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            emit_reg         <= emit_next;
            start_codes_reg  <= start_codes_next;
            alpha_reg        <= alpha_next;
            free_reg         <= free_next;
            prefix_empty_reg <= prefix_empty_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prefix_reg     <= prefix_next;
        sym_reg        <= sym_next;
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        pend_valid_reg <= pend_valid_next;
        pend_code_reg  <= pend_code_next;
        pend_full_reg  <= pend_full_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

[tb/lzw_checker.sv]
`timescale 1ns / 100ps
// Stream monitor for the LZW encoder: predicts every result word and compares it.
module lzw_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [lzw_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [lzw_pkg::SYM_W-1:0]    s_tdata,   // [7:0] symbol
    input  logic                         s_tuser,   // [0] opcode
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [lzw_pkg::TDATA_W-1:0]  m_tdata,   // [11:0] code, [24:12] next_code,
                                                    // [25] dict_full
    input  logic                         m_tuser,   // [0] code_valid
    output int                           fail_count,
    output int                           pending,
    output int                           words_seen,
    output int                           codes_seen,
    output int                           full_seen
);
    import lzw_pkg::*;

    localparam int                DICT_SIZE   = DEF_MAX_CODES;
    localparam logic [NEXT_W-1:0] NO_PREFIX   = DICT_SIZE[NEXT_W-1:0];

    typedef struct packed {
        logic              code_valid;
        logic [CODE_W-1:0] code;
        logic [NEXT_W-1:0] next_code;
        logic              dict_full;
    } lzw_result_t;

    // Encoder state as the stream sees it
    logic [CFG_W-1:0]  start_codes_reg;
    logic [CFG_W-1:0]  alphabet;
    logic [NEXT_W-1:0] prefix;
    logic [NEXT_W-1:0] free_code;
    logic [CODE_W-1:0] string_table [int];
    lzw_result_t       expected_codes [$];

    function automatic logic [CFG_W-1:0] clamp_alphabet(input logic [CFG_W-1:0] v);
        if (v < 2)
            return 9'd2;
        if (v > 256)
            return 9'd256;
        return v;
    endfunction

    task automatic restart_dictionary();
        string_table.delete();
        alphabet  = clamp_alphabet(start_codes_reg);
        free_code = NEXT_W'(alphabet);
        prefix    = NO_PREFIX;
    endtask

    // Advance the string table for one input word and queue the result it causes
    task automatic encode_symbol(input opcode_t op, input logic [SYM_W-1:0] sym);
        lzw_result_t want;
        int          pair;
        want = '0;
        if (op == OP_CLEAR)
            restart_dictionary();
        else if (sym < alphabet)
        begin
            if (prefix == NO_PREFIX)
                prefix = NEXT_W'(sym);
            else
            begin
                pair = int'(prefix) * 256 + int'(sym);
                if (string_table.exists(pair))
                    prefix = NEXT_W'(string_table[pair]);
                else
                begin
                    want.code_valid = 1'b1;
                    want.code       = prefix[CODE_W-1:0];
                    if (free_code < DICT_SIZE)
                    begin
                        string_table[pair] = free_code[CODE_W-1:0];
                        free_code          = free_code + 1'b1;
                    end
                    else
                        want.dict_full = 1'b1;
                    prefix = NEXT_W'(sym);
                end
            end
        end
        want.next_code = free_code;
        expected_codes.push_back(want);
    endtask

    task automatic report_field(input string field, input int want, input int got);
        fail_count++;
        $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Compare one result word with the oldest prediction
    task automatic check_result(input lzw_result_t got);
        lzw_result_t want;
        words_seen++;
        if (got.code_valid)
            codes_seen++;
        if (got.dict_full)
            full_seen++;
        if (expected_codes.size() == 0)
        begin
            fail_count++;
            $display("[%0t] result word with nothing expected: expected none, actual %h",
                     $time, got);
        end
        else
        begin
            want = expected_codes.pop_front();
            if (got.code_valid !== want.code_valid)
                report_field("code_valid", int'(want.code_valid), int'(got.code_valid));
            if (got.code !== want.code)
                report_field("code", int'(want.code), int'(got.code));
            if (got.next_code !== want.next_code)
                report_field("next_code", int'(want.next_code), int'(got.next_code));
            if (got.dict_full !== want.dict_full)
                report_field("dict_full", int'(want.dict_full), int'(got.dict_full));
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_codes.delete();
            start_codes_reg = START_CODES_RESET;
            restart_dictionary();
            fail_count = 0;
            pending    = 0;
            words_seen = 0;
            codes_seen = 0;
            full_seen  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                start_codes_reg = cfg_data;
            if (s_tvalid && s_tready)
                encode_symbol(opcode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                check_result({m_tuser, m_tdata[CODE_W-1:0],
                              m_tdata[CODE_W+NEXT_W-1:CODE_W], m_tdata[CODE_W+NEXT_W]});
            pending = expected_codes.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the LZW encoder: clock, reset, symbol stimulus and verdict.
module tb_top;
    import lzw_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 8;
    localparam int SWEEP_WAIT   = DEF_MAX_CODES + 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 150;
    localparam int FILL_WORDS   = 230;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int NUM_SETTINGS = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SYM_W-1:0]    s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;

    int                  fail_count;
    int                  pending;
    int                  words_seen;
    int                  codes_seen;
    int                  full_seen;

    bit                  sender_idles    = 1'b1;
    bit                  receiver_stalls = 1'b1;
    bit                  hold_request    = 1'b0;
    int                  stall_left      = 0;
    int                  settings_done   = 0;
    logic [CFG_W-1:0]    alphabet_now    = START_CODES_RESET;

    always #(HALF_PERIOD) clk = ~clk;

    lzw_dictionary_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lzw_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .words_seen (words_seen),
        .codes_seen (codes_seen),
        .full_seen  (full_seen)
    );

    // Offer one word from a falling edge and hold it until it is taken
    task automatic send_word(input opcode_t op, input logic [SYM_W-1:0] sym);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop the input, let every result drain and any dictionary sweep finish
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SWEEP_WAIT) @(negedge clk);
    endtask

    // New alphabet: write the register while idle, then clear to latch it
    task automatic start_phase(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_done++;
        send_word(OP_CLEAR, 8'($urandom));
        alphabet_now = (value < 2) ? 9'd2 : (value > 256) ? 9'd256 : value;
    endtask

    // Mostly in-alphabet symbols, biased to a few values so strings repeat
    task automatic send_random_word();
        int               pick;
        logic [SYM_W-1:0] sym;
        pick = $urandom_range(0, 99);
        if (pick == 0)
            send_word(OP_CLEAR, 8'($urandom));
        else
        begin
            if (pick < 12)
                sym = 8'($urandom_range(0, 255));
            else if (pick < 55)
                sym = 8'($urandom_range(0, (alphabet_now < 4) ? alphabet_now - 1 : 3));
            else
                sym = 8'($urandom_range(0, alphabet_now - 1));
            send_word(OP_ENCODE, sym);
        end
    endtask

    // Result side: random stall bursts, plus one long hold on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        logic [CFG_W-1:0] settings [NUM_SETTINGS];
        settings = '{9'd0, 9'd1, 9'd511, 9'd257, 9'd2, 9'd17, 9'd128, 9'd255, 9'd256, 9'd100};
        settings[NUM_SETTINGS-1] = CFG_W'($urandom_range(3, 254));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty prefix, new pair, known pair, extreme symbols, clear
        send_word(OP_ENCODE, 8'h00);
        send_word(OP_ENCODE, 8'h00);
        send_word(OP_ENCODE, 8'h00);
        send_word(OP_ENCODE, 8'h00);
        send_word(OP_ENCODE, 8'hFF);
        send_word(OP_ENCODE, 8'hFF);
        send_word(OP_ENCODE, 8'hFF);
        send_word(OP_ENCODE, 8'h55);
        send_word(OP_ENCODE, 8'hAA);
        send_word(OP_ENCODE, 8'h01);
        send_word(OP_ENCODE, 8'h80);
        send_word(OP_CLEAR, 8'hFF);
        send_word(OP_ENCODE, 8'h07);
        send_word(OP_ENCODE, 8'h07);

        // Directed: tiny alphabet, symbols outside it are dropped
        start_phase(9'd3);
        send_word(OP_ENCODE, 8'h02);
        send_word(OP_ENCODE, 8'h03);
        send_word(OP_ENCODE, 8'hFF);
        send_word(OP_ENCODE, 8'h02);
        send_word(OP_ENCODE, 8'h00);
        send_word(OP_ENCODE, 8'h02);

        // Random phases across register settings, out-of-range values included
        for (int idx = 0; idx < NUM_SETTINGS; idx++)
        begin
            start_phase(settings[idx]);
            sender_idles    = (idx % 3 != 2);
            receiver_stalls = (idx % 4 != 3);
            if (idx == 3)
            begin
                repeat (20) send_random_word();
                sender_idles = 1'b0;
                hold_request = 1'b1;
                repeat (PHASE_WORDS - 20) send_random_word();
            end
            else
                repeat (PHASE_WORDS) send_random_word();
        end

        // Closing stretch at the full alphabet, no idling from here on
        start_phase(9'd256);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        repeat (FILL_WORDS) send_word(OP_ENCODE, 8'($urandom));

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Checked %0d result words, %0d codes emitted, %0d refused for a full table",
                 words_seen, codes_seen, full_seen);
        $display("Alphabet settings exercised: %0d, including clamped extremes",
                 settings_done);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
        $display("Verification failed");
        $finish;
    end

endmodule
